// ----- src/stpg_pkg.sv -----
`timescale 1ns / 1ps

package stpg_pkg;

    // default build parameters
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // configuration port shape
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 1;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LITTLE_ENDIAN   = 2'd0,
        CFG_UNSIGNED_FORMAT = 2'd1,
        CFG_SIXTEEN_BIT     = 2'd2
    } cfg_reg_t;

    // full-scale amplitudes
    localparam logic signed [16:0] MAX16 = 17'sd32767;
    localparam logic signed [16:0] MAX8  = 17'sd127;

    // byte counts
    localparam logic [1:0] BYTES_8  = 2'd1;
    localparam logic [1:0] BYTES_16 = 2'd2;

    // pi/2 with 62 fraction bits
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // divide by fifteen: ceil(2^24 / 15), exact for dividends below 2^20
    localparam logic [20:0] DIV15_RECIP = 21'd1118482;
    localparam int          DIV15_SHIFT = 24;

    // table entry: 16-bit magnitude (15 bits) over 8-bit magnitude (7 bits)
    localparam int ENTRY_W = 22;
    typedef logic [ENTRY_W-1:0] sine_entry_t;

    typedef struct packed {
        logic [31:0] sample_index;
        logic [31:0] phase_step;
        logic [3:0]  volume;
    } req_item_t;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [1:0] byte_count;
    } pcm_item_t;

    typedef struct packed {
        logic little_endian;
        logic unsigned_format;
        logic sixteen_bit;
    } cfg_t;

    // (a * b) >> 62, kept to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // round(amp * s / 2^62), halves rounded up, clamped to amp
    function automatic logic [63:0] scale_round(input logic [63:0] s, input logic [63:0] amp);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        logic [63:0] r;
        a = amp * {31'd0, s[63:31]};
        b = amp * {33'd0, s[30:0]};
        t = a + (b >> 31);
        r = (t + (64'd1 << 30)) >> 31;
        if (r > amp)
        begin
            r = amp;
        end
        return r;
    endfunction

    // quarter-wave magnitude for entry j of a table of 2^table_bits points;
    // the last entry stands for exactly a quarter turn
    function automatic sine_entry_t sine_entry(input int j, input int table_bits);
        logic [63:0] unit;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r16;
        logic [63:0] r8;
        int          n;
        unit = HALF_PI_Q62 >> (table_bits - 2);
        x    = (j == (1 << (table_bits - 2))) ? HALF_PI_Q62 : unit * 64'(j);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        // taylor series, thirteen terms after the first
        for (n = 1; n <= 13; n++)
        begin
            term = mul_q62(term, x2);
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                9:       term = term / 64'd342;
                10:      term = term / 64'd420;
                11:      term = term / 64'd506;
                12:      term = term / 64'd600;
                default: term = term / 64'd702;
            endcase
            if (n[0])
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        r16 = scale_round(sum, 64'd32767);
        r8  = scale_round(sum, 64'd127);
        return {r16[14:0], r8[6:0]};
    endfunction

endpackage

// ----- src/stpg_phase.sv -----
`timescale 1ns / 1ps

module stpg_phase #(
    parameter int PHASE_BITS = stpg_pkg::PHASE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  in_valid,
    input  stpg_pkg::req_item_t   in_item,
    output logic                  valid_reg,
    output logic [PHASE_BITS-1:0] phase_reg,
    output logic                  silent_reg,
    output logic [3:0]            volume_reg
);
    import stpg_pkg::*;

    logic [31:0]           prod_low;
    logic [PHASE_BITS-1:0] phase_next;

    // only the low product bits matter for the wrapped phase
    assign prod_low   = in_item.sample_index * in_item.phase_step;
    assign phase_next = prod_low[PHASE_BITS-1:0];

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            phase_reg  <= phase_next;
            silent_reg <= (in_item.phase_step == 32'd0);
            volume_reg <= in_item.volume;
        end
    end

endmodule

// ----- src/stpg_sine_rom.sv -----
`timescale 1ns / 1ps

module stpg_sine_rom #(
    parameter int PHASE_BITS      = stpg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = stpg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [PHASE_BITS-1:0] phase,
    input  logic                  silent,
    input  logic [3:0]            volume,
    output logic                  valid_reg,
    output stpg_pkg::sine_entry_t entry_reg,
    output logic                  negate_reg,
    output logic                  silent_reg,
    output logic [3:0]            volume_reg
);
    import stpg_pkg::*;

    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int ADDR_W  = SINE_TABLE_BITS - 1;
    localparam logic [ADDR_W-1:0] QUARTER_VEC = ADDR_W'(QUARTER);

    logic [SINE_TABLE_BITS-1:0] table_idx;
    logic [1:0]                 quadrant;
    logic [ADDR_W-1:0]          offset;
    logic [ADDR_W-1:0]          rom_addr;
    sine_entry_t                rom_tab [QUARTER+1];

    // quarter-wave table, fixed contents
    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_rom
        assign rom_tab[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    // fold the full-turn index onto the first quadrant
    assign table_idx = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign quadrant  = table_idx[SINE_TABLE_BITS-1 -: 2];
    assign offset    = {1'b0, table_idx[SINE_TABLE_BITS-3:0]};
    assign rom_addr  = quadrant[0] ? (QUARTER_VEC - offset) : offset;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // registered table read
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            entry_reg  <= rom_tab[rom_addr];
            negate_reg <= quadrant[1];
            silent_reg <= silent;
            volume_reg <= volume;
        end
    end

endmodule

// ----- src/stpg_scale.sv -----
`timescale 1ns / 1ps

module stpg_scale (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  stpg_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    input  stpg_pkg::sine_entry_t entry,
    input  logic                  negate,
    input  logic                  silent,
    input  logic [3:0]            volume,
    output logic                  valid_reg,
    output logic signed [21:0]    prod_reg,
    output logic                  silent_reg
);
    import stpg_pkg::*;

    logic [16:0]        mag;
    logic signed [16:0] signed_samp;
    logic signed [16:0] samp;
    logic signed [21:0] prod_next;

    // pick the magnitude, restore the sign, add the offset if asked, and multiply by the volume
    always_comb
    begin
        mag         = cfg.sixteen_bit ? {2'b00, entry[21:7]} : {10'd0, entry[6:0]};
        signed_samp = negate ? -$signed(mag) : $signed(mag);
        samp        = signed_samp;
        if (cfg.unsigned_format)
        begin
            samp = signed_samp + (cfg.sixteen_bit ? MAX16 : MAX8);
        end
        prod_next = $signed({{5{samp[16]}}, samp}) * $signed({18'd0, volume});
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg   <= prod_next;
            silent_reg <= silent;
        end
    end

endmodule

// ----- src/stpg_pack.sv -----
`timescale 1ns / 1ps

module stpg_pack (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  stpg_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  logic signed [21:0]  prod,
    input  logic                silent,
    output logic                valid_reg,
    output stpg_pkg::pcm_item_t out_reg
);
    import stpg_pkg::*;

    logic [21:0]  mag_p;
    logic [40:0]  quot_prod;
    logic [15:0]  quot;
    logic [15:0]  bits;
    pcm_item_t    out_next;

    // divide by fifteen toward zero through a reciprocal multiply; a silent item gives zero
    always_comb
    begin
        mag_p     = prod[21] ? (~prod + 22'd1) : prod;
        quot_prod = {21'd0, mag_p[19:0]} * {20'd0, DIV15_RECIP};
        quot      = quot_prod[DIV15_SHIFT+15:DIV15_SHIFT];
        if (silent)
        begin
            bits = 16'd0;
        end
        else if (prod[21])
        begin
            bits = ~quot + 16'd1;
        end
        else
        begin
            bits = quot;
        end
    end

    // byte order and width
    always_comb
    begin
        if (cfg.sixteen_bit)
        begin
            out_next.first_byte  = cfg.little_endian ? bits[7:0] : bits[15:8];
            out_next.second_byte = cfg.little_endian ? bits[15:8] : bits[7:0];
            out_next.byte_count  = BYTES_16;
        end
        else
        begin
            out_next.first_byte  = bits[7:0];
            out_next.second_byte = 8'd0;
            out_next.byte_count  = BYTES_8;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- src/sine_tone_pcm_sample_generator.sv -----
`timescale 1ns / 1ps
// throughput: one sample per cycle while the output is not stalled, set by the four register
// stages (phase multiplier, sine table read, volume multiply, divide-by-fifteen and packing
// into the output register)
// each stage moves on when it is empty or the next one moves, so bubbles close up
// reset: clears all stage valid bits and returns the configuration to little-endian,
// signed, 16-bit; the sine table is constant and needs no clearing

module sine_tone_pcm_sample_generator #(
    parameter int SINE_TABLE_BITS = stpg_pkg::SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = stpg_pkg::PHASE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [stpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [stpg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  stpg_pkg::req_item_t                 req,
    output logic                                pcm_valid,
    input  logic                                pcm_stall,
    output stpg_pkg::pcm_item_t                 pcm
);
    import stpg_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;

    logic                  adv_a;
    logic                  adv_b;
    logic                  adv_c;
    logic                  adv_d;

    logic                  valid_a;
    logic [PHASE_BITS-1:0] phase_a;
    logic                  silent_a;
    logic [3:0]            volume_a;

    logic                  valid_b;
    sine_entry_t           entry_b;
    logic                  negate_b;
    logic                  silent_b;
    logic [3:0]            volume_b;

    logic                  valid_c;
    logic signed [21:0]    prod_c;
    logic                  silent_c;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LITTLE_ENDIAN:   cfg_next.little_endian   = cfg_wdata[0];
                CFG_UNSIGNED_FORMAT: cfg_next.unsigned_format = cfg_wdata[0];
                CFG_SIXTEEN_BIT:     cfg_next.sixteen_bit     = cfg_wdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.little_endian   <= 1'b1;
            cfg_reg.unsigned_format <= 1'b0;
            cfg_reg.sixteen_bit     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // stage advance chain, output side first
    assign adv_d     = !pcm_valid || !pcm_stall;
    assign adv_c     = !valid_c || adv_d;
    assign adv_b     = !valid_b || adv_c;
    assign adv_a     = !valid_a || adv_b;
    assign req_stall = !adv_a;

    // phase multiply
    stpg_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (adv_a),
        .in_valid   (req_valid),
        .in_item    (req),
        .valid_reg  (valid_a),
        .phase_reg  (phase_a),
        .silent_reg (silent_a),
        .volume_reg (volume_a)
    );

    // sine table read
    stpg_sine_rom #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (adv_b),
        .in_valid   (valid_a),
        .phase      (phase_a),
        .silent     (silent_a),
        .volume     (volume_a),
        .valid_reg  (valid_b),
        .entry_reg  (entry_b),
        .negate_reg (negate_b),
        .silent_reg (silent_b),
        .volume_reg (volume_b)
    );

    // sign, offset and volume
    stpg_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (adv_c),
        .cfg        (cfg_reg),
        .in_valid   (valid_b),
        .entry      (entry_b),
        .negate     (negate_b),
        .silent     (silent_b),
        .volume     (volume_b),
        .valid_reg  (valid_c),
        .prod_reg   (prod_c),
        .silent_reg (silent_c)
    );

    // divide, pack and output register
    stpg_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (adv_d),
        .cfg       (cfg_reg),
        .in_valid  (valid_c),
        .prod      (prod_c),
        .silent    (silent_c),
        .valid_reg (pcm_valid),
        .out_reg   (pcm)
    );

    // an accepted transaction always lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> valid_a)
    else $error("accepted transaction lost at the first stage");

    // a full pipeline behind a stalled output must hold off requests
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_a && valid_b && valid_c && pcm_valid && pcm_stall |-> req_stall)
    else $error("request taken while the pipeline is full and stalled");

    // 8-bit samples carry an empty second byte
    assert property (@(posedge clk) disable iff (!rst_n)
        pcm_valid && pcm.byte_count == BYTES_8 |-> pcm.second_byte == 8'd0)
    else $error("second byte set on an 8-bit sample");

endmodule
